FILE: hw/rtl/mvne_pkg.sv
// Package for the mesh vertex normal engine.
// Holds the request and response types, command codes, sequencer states and
// the saturation helpers; it depends on nothing else.
`default_nettype none

package mvne_pkg;

   // The vertex depth must be a power of two: indexes wrap by truncation.
   localparam int VERTEX_DEPTH = 1024;
   localparam int COORD_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 12;

   localparam int VIDX_W   = $clog2(VERTEX_DEPTH);
   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int NORMAL_W = 36;
   localparam int SUM_W    = 48;
   localparam int VTX_W    = 3 * COORD_WIDTH;
   localparam int ACC_W    = COUNT_WIDTH + 3 * SUM_W;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic signed [63:0] NORMAL_HI = (64'sd1 <<< (NORMAL_W - 1)) - 64'sd1;
   localparam logic signed [63:0] NORMAL_LO = -NORMAL_HI - 64'sd1;
   localparam logic signed [63:0] SUM_HI    = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
   localparam logic signed [63:0] SUM_LO    = -SUM_HI - 64'sd1;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_TRI   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_FACE  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         vertex_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [35:0] normal_x;
      logic signed [35:0] normal_y;
      logic signed [35:0] normal_z;
      logic [11:0]        face_count;
      logic               no_faces;
      logic               count_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_TRI_RD,
      ST_DIFF,
      ST_MUL,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_Q_RD,
      ST_Q_CAP,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_END,
      ST_RESP
   } state_type;

   function automatic logic [VIDX_W-1:0] wrap_index(input logic [9:0] i);
      return VIDX_W'(i);
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] to_coord(input logic signed [15:0] v);
      logic [15:0] raw;
      raw = v;
      return COORD_WIDTH'(raw);
   endfunction

   function automatic logic signed [NORMAL_W-1:0] sat_normal(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > NORMAL_HI) r = NORMAL_HI;
      if (v < NORMAL_LO) r = NORMAL_LO;
      return NORMAL_W'(r);
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > SUM_HI) r = SUM_HI;
      if (v < SUM_LO) r = SUM_LO;
      return SUM_W'(r);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mvne_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the vertex store and the accumulator store.
`default_nettype none

module mvne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mesh_vertex_normal_engine_unit.sv
// Top level of the mesh vertex normal engine: sequencer, shared multiplier
// and divider. Depends on mvne_pkg and mvne_ram.
//
// A request with a known command is taken when start is high and busy is low;
// busy then stays high until the single response has been strobed for one
// cycle, and the receiver cannot stall it. After reset the block clears the
// face counts of all VERTEX_DEPTH entries before it takes its first request.
// An add-triangle does three vertex reads, six products on one multiplier,
// then a read-modify-write per distinct corner on the accumulator RAM. A
// query with no faces skips the divider; otherwise the divider runs over 48
// bits for each component at one quotient bit per cycle.
`default_nettype none

module mesh_vertex_normal_engine_unit
   import mvne_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   state_type state_ff, state_in;

   req_type                         req_ff;
   logic [STEP_W-1:0]               step_ff;
   logic [VIDX_W-1:0]               clr_ff;
   logic [1:0]                      corner_ff;
   logic [VTX_W-1:0]                va_ff, vb_ff, vc_ff;
   logic signed [DIFF_W-1:0]        u_ff [3];
   logic signed [DIFF_W-1:0]        w_ff [3];
   logic signed [PROD_W-1:0]        prod_ff, first_ff;
   logic signed [NORMAL_W-1:0]      nrm_ff [3];
   logic                            full_ff;
   logic signed [SUM_W-1:0]         sum_ff [3];
   logic [COUNT_WIDTH-1:0]          cnt_ff;
   logic [COUNT_WIDTH-1:0]          rem_ff;
   logic [SUM_W-1:0]                quo_ff;
   logic                            neg_ff;
   logic [1:0]                      comp_ff;

   logic                            vtx_wr_en;
   logic [VIDX_W-1:0]               vtx_wr_addr, vtx_rd_addr;
   logic [VTX_W-1:0]                vtx_wr_data, vtx_rd_data;
   logic                            acc_wr_en;
   logic [VIDX_W-1:0]               acc_wr_addr, acc_rd_addr;
   logic [ACC_W-1:0]                acc_wr_data, acc_rd_data;

   logic [VIDX_W-1:0]               idx_a, idx_b, idx_c, corner_idx, query_idx;
   logic                            corner_dup;
   logic signed [DIFF_W-1:0]        mul_a, mul_b;
   logic signed [PROD_W-1:0]        prod;
   logic [COUNT_WIDTH-1:0]          rd_cnt;
   logic signed [SUM_W-1:0]         rd_sum [3];
   logic signed [SUM_W-1:0]         new_sum [3];
   logic [COUNT_WIDTH:0]            trial;
   logic                            trial_ok;

   mvne_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
      .clock   (clock),
      .wr_en   (vtx_wr_en),
      .wr_addr (vtx_wr_addr),
      .wr_data (vtx_wr_data),
      .rd_addr (vtx_rd_addr),
      .rd_data (vtx_rd_data)
   );

   mvne_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   assign idx_a     = wrap_index(req_ff.corner_a);
   assign idx_b     = wrap_index(req_ff.corner_b);
   assign idx_c     = wrap_index(req_ff.corner_c);
   assign query_idx = wrap_index(req_ff.vertex_index);

   always_comb begin
      corner_idx = idx_a;
      corner_dup = 1'b0;
      case (corner_ff)
         2'd1: begin
            corner_idx = idx_b;
            corner_dup = (idx_b == idx_a);
         end
         2'd2: begin
            corner_idx = idx_c;
            corner_dup = (idx_c == idx_a) || (idx_c == idx_b);
         end
         default: begin
            corner_idx = idx_a;
            corner_dup = 1'b0;
         end
      endcase
   end

   // Operand order for n = u x w, two products per component.
   always_comb begin
      case (step_ff)
         STEP_W'(0): begin mul_a = u_ff[1]; mul_b = w_ff[2]; end
         STEP_W'(1): begin mul_a = u_ff[2]; mul_b = w_ff[1]; end
         STEP_W'(2): begin mul_a = u_ff[2]; mul_b = w_ff[0]; end
         STEP_W'(3): begin mul_a = u_ff[0]; mul_b = w_ff[2]; end
         STEP_W'(4): begin mul_a = u_ff[0]; mul_b = w_ff[1]; end
         default:    begin mul_a = u_ff[1]; mul_b = w_ff[0]; end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign rd_cnt = acc_rd_data[ACC_W-1 -: COUNT_WIDTH];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // A count of zero means the sums are stale and read as zero.
         rd_sum[k]  = (rd_cnt == '0) ? '0 : signed'(acc_rd_data[k*SUM_W +: SUM_W]);
         new_sum[k] = sat_sum(64'(rd_sum[k]) + 64'(nrm_ff[k]));
      end
   end

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ok = trial >= {1'b0, cnt_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == VIDX_W'(VERTEX_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               case (req_data.command)
                  CMD_LOAD:  state_in = ST_LOAD;
                  CMD_TRI:   state_in = ST_TRI_RD;
                  CMD_QUERY: state_in = ST_Q_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:   state_in = ST_RESP;
         ST_TRI_RD: if (step_ff == STEP_W'(3)) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    if (step_ff == STEP_W'(6)) state_in = ST_ACC_RD;
         ST_ACC_RD: begin
            if (!corner_dup) state_in = ST_ACC_WR;
            else if (corner_ff == 2'd2) state_in = ST_RESP;
         end
         ST_ACC_WR: state_in = (corner_ff == 2'd2) ? ST_RESP : ST_ACC_RD;
         ST_Q_RD:   state_in = ST_Q_CAP;
         ST_Q_CAP:  state_in = (rd_cnt == '0) ? ST_RESP : ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:    if (step_ff == STEP_W'(SUM_W - 1)) state_in = ST_DIV_END;
         ST_DIV_END: state_in = (comp_ff == 2'd2) ? ST_RESP : ST_DIV_INIT;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy        = (state_ff != ST_IDLE);
      vtx_wr_en   = (state_ff == ST_LOAD);
      vtx_wr_addr = query_idx;
      vtx_wr_data = {to_coord(req_ff.coord_z), to_coord(req_ff.coord_y),
                     to_coord(req_ff.coord_x)};
      vtx_rd_addr = idx_a;
      case (step_ff)
         STEP_W'(1): vtx_rd_addr = idx_b;
         STEP_W'(2): vtx_rd_addr = idx_c;
         default:    vtx_rd_addr = idx_a;
      endcase
      acc_rd_addr = (state_ff == ST_Q_RD) ? query_idx : corner_idx;
      acc_wr_en   = 1'b0;
      acc_wr_addr = corner_idx;
      acc_wr_data = {rd_cnt + COUNT_WIDTH'(1), new_sum[2], new_sum[1], new_sum[0]};
      case (state_ff)
         ST_CLEAR: begin
            acc_wr_en   = 1'b1;
            acc_wr_addr = clr_ff;
            acc_wr_data = '0;
         end
         ST_LOAD: begin
            acc_wr_en   = 1'b1;
            acc_wr_addr = query_idx;
            acc_wr_data = '0;
         end
         ST_ACC_WR: acc_wr_en = (rd_cnt != COUNT_MAX);
         default:   acc_wr_en = 1'b0;
      endcase

      rsp_strobe = (state_ff == ST_RESP);
      rsp_data   = '0;
      case (req_ff.command)
         CMD_TRI: begin
            rsp_data.result_kind = KIND_FACE;
            rsp_data.normal_x    = nrm_ff[0];
            rsp_data.normal_y    = nrm_ff[1];
            rsp_data.normal_z    = nrm_ff[2];
            rsp_data.count_full  = full_ff;
         end
         CMD_QUERY: begin
            rsp_data.result_kind = KIND_QUERY;
            rsp_data.face_count  = 12'(cnt_ff);
            rsp_data.no_faces    = (cnt_ff == '0);
            rsp_data.count_full  = (cnt_ff == COUNT_MAX);
            if (cnt_ff != '0) begin
               rsp_data.normal_x = nrm_ff[0];
               rsp_data.normal_y = nrm_ff[1];
               rsp_data.normal_z = nrm_ff[2];
            end
         end
         default: rsp_data.result_kind = KIND_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + VIDX_W'(1);
            ST_IDLE: begin
               req_ff    <= req_data;
               step_ff   <= '0;
               corner_ff <= 2'd0;
               comp_ff   <= 2'd0;
               full_ff   <= 1'b0;
            end
            ST_TRI_RD: begin
               step_ff <= step_ff + STEP_W'(1);
               case (step_ff)
                  STEP_W'(1): va_ff <= vtx_rd_data;
                  STEP_W'(2): vb_ff <= vtx_rd_data;
                  STEP_W'(3): vc_ff <= vtx_rd_data;
                  default: ;
               endcase
            end
            ST_DIFF: begin
               step_ff <= '0;
               for (int k = 0; k < 3; k++) begin
                  u_ff[k] <= DIFF_W'(signed'(vb_ff[k*COORD_WIDTH +: COORD_WIDTH]))
                           - DIFF_W'(signed'(va_ff[k*COORD_WIDTH +: COORD_WIDTH]));
                  w_ff[k] <= DIFF_W'(signed'(vc_ff[k*COORD_WIDTH +: COORD_WIDTH]))
                           - DIFF_W'(signed'(vb_ff[k*COORD_WIDTH +: COORD_WIDTH]));
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + STEP_W'(1);
               prod_ff <= prod;
               case (step_ff)
                  STEP_W'(1), STEP_W'(3), STEP_W'(5): first_ff <= prod_ff;
                  STEP_W'(2): nrm_ff[0] <= sat_normal(64'(first_ff) - 64'(prod_ff));
                  STEP_W'(4): nrm_ff[1] <= sat_normal(64'(first_ff) - 64'(prod_ff));
                  STEP_W'(6): nrm_ff[2] <= sat_normal(64'(first_ff) - 64'(prod_ff));
                  default: ;
               endcase
            end
            ST_ACC_RD: if (corner_dup) corner_ff <= corner_ff + 2'd1;
            ST_ACC_WR: begin
               corner_ff <= corner_ff + 2'd1;
               if (rd_cnt == COUNT_MAX) full_ff <= 1'b1;
            end
            ST_Q_CAP: begin
               cnt_ff <= rd_cnt;
               for (int k = 0; k < 3; k++) sum_ff[k] <= rd_sum[k];
            end
            ST_DIV_INIT: begin
               step_ff <= '0;
               rem_ff  <= '0;
               neg_ff  <= sum_ff[comp_ff][SUM_W-1];
               quo_ff  <= sum_ff[comp_ff][SUM_W-1] ? SUM_W'(-sum_ff[comp_ff])
                                                  : SUM_W'(sum_ff[comp_ff]);
            end
            ST_DIV: begin
               step_ff <= step_ff + STEP_W'(1);
               rem_ff  <= trial_ok ? COUNT_WIDTH'(trial - {1'b0, cnt_ff})
                                   : COUNT_WIDTH'(trial);
               quo_ff  <= {quo_ff[SUM_W-2:0], trial_ok};
            end
            ST_DIV_END: begin
               comp_ff <= comp_ff + 2'd1;
               nrm_ff[comp_ff] <= sat_normal(neg_ff ? -64'(quo_ff) : 64'(quo_ff));
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mvne_checker.sv
// Port-level checker for the mesh vertex normal engine, bound to the top level.
// Depends on mvne_pkg for the request and response types.
`default_nettype none

module mvne_checker
   import mvne_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("Block is not clearing after reset.");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command != 2'd3) |=> busy)
      else $error("Block did not go busy after taking a request.");

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("Response strobed while idle.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("Response strobe held or block stayed busy.");

   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.result_kind != 2'd3))
      else $error("Response has an unknown result kind.");

endmodule

bind mesh_vertex_normal_engine_unit mvne_checker u_mvne_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
